// ===== rtl/core/cmnd_pkg.sv =====
// ----------------------------------------------------------------------------
// cmnd_pkg
// Shared types and constants of the cumulative mean normalized difference
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmnd_pkg;

  localparam int unsigned DiffWidth  = 32;
  localparam int unsigned NormWidth  = 32;
  localparam int unsigned LagWidth   = 10;
  localparam int unsigned IntBits    = 8;
  localparam int unsigned QuotBits   = 32;

  localparam logic [NormWidth-1:0] OneQ824 = 32'h0100_0000;
  localparam logic [NormWidth-1:0] MaxCode = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [DiffWidth-1:0] diff_value;
    logic                 window_end;
  } cmnd_in_t;

  typedef struct packed {
    logic [NormWidth-1:0] norm_value;
    logic                 zero_sum;
    logic [LagWidth-1:0]  lag_index;
    logic                 result_last;
  } cmnd_out_t;

  typedef struct packed {
    logic                last;
    logic                lag0;
    logic                zero_sum;
    logic                ovf;
    logic [LagWidth-1:0] lag_index;
  } cmnd_meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmnd_accum.sv =====
// ----------------------------------------------------------------------------
// cmnd_accum
// Lag counter and saturating running sum of one window.
// ----------------------------------------------------------------------------
`default_nettype none

module cmnd_accum import cmnd_pkg::*; #(
  parameter int unsigned MAX_LAGS    = 1024,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned LW          = (MAX_LAGS > 2) ? $clog2(MAX_LAGS) : 1,
  parameter int unsigned TW          = VALUE_WIDTH + 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic                   last_i,
  output logic      [LW-1:0]          lag_o,
  output logic      [TW-1:0]          den_o
);

  localparam logic [LW-1:0] LagMax = LW'(MAX_LAGS - 1);

  logic [LW-1:0] lag_q;
  logic [TW-1:0] total_q;
  logic [TW:0]   sum_w;
  logic [TW-1:0] sat_w;

  always_comb begin
    sum_w = {1'b0, total_q} + (TW + 1)'(value_i);
    sat_w = sum_w[TW] ? {TW{1'b1}} : sum_w[TW-1:0];
  end

  assign lag_o = lag_q;
  assign den_o = sat_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q   <= '0;
      total_q <= '0;
    end else if (take_i) begin
      if (last_i) begin
        lag_q   <= '0;
        total_q <= '0;
      end else begin
        if (lag_q != '0) begin
          total_q <= sat_w;
        end
        if (lag_q < LagMax) begin
          lag_q <= lag_q + LW'(1);
        end
      end
    end
  end

  a_lag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q <= LagMax)
    else $error("lag counter beyond window length");

  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_i |=> lag_q == '0 && total_q == '0)
    else $error("window state not cleared after last lag");

  a_lag0_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q == '0 |-> total_q == '0)
    else $error("running sum non-zero at lag zero");

endmodule

`default_nettype wire

// ===== rtl/core/cmnd_div_cell.sv =====
// ----------------------------------------------------------------------------
// cmnd_div_cell
// One restoring-division cell: produce one quotient bit and pass the
// partial remainder on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cmnd_div_cell import cmnd_pkg::*; #(
  parameter int unsigned TW   = 42,
  parameter int unsigned STEP = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [TW-1:0]       den_i,
  input  wire logic [TW-1:0]       rem_i,
  input  wire logic [IntBits-1:0]  num_lo_i,
  input  wire logic [QuotBits-1:0] quot_i,
  input  wire cmnd_meta_t          meta_i,
  output logic                     valid_o,
  output logic      [TW-1:0]       den_o,
  output logic      [TW-1:0]       rem_o,
  output logic      [IntBits-1:0]  num_lo_o,
  output logic      [QuotBits-1:0] quot_o,
  output cmnd_meta_t               meta_o
);

  logic          nb_w;
  logic [TW:0]   trial_w;
  logic          ge_w;
  logic [TW:0]   diff_w;

  if (STEP < IntBits) begin : g_int
    assign nb_w = num_lo_i[IntBits-1-STEP];
  end else begin : g_frac
    assign nb_w = 1'b0;
  end

  always_comb begin
    trial_w = {rem_i, nb_w};
    ge_w    = trial_w >= {1'b0, den_i};
    diff_w  = trial_w - {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o    <= den_i;
      rem_o    <= ge_w ? diff_w[TW-1:0] : trial_w[TW-1:0];
      num_lo_o <= num_lo_i;
      quot_o   <= {quot_i[QuotBits-2:0], ge_w};
      meta_o   <= meta_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cumulative_mean_normalized_difference.sv =====
// ----------------------------------------------------------------------------
// cumulative_mean_normalized_difference
// YIN cumulative mean normalized difference over a stream of lag values.
// ----------------------------------------------------------------------------
// An accepted value updates the saturating running sum at once, is
// multiplied by its lag from stage a into stage b, checked for quotient
// overflow, and then passes a row of 32 restoring-division cells, one
// quotient bit per cell, before the output register. The row holds up to
// 36 transactions, so with the output drained a new item is taken every
// cycle. A stalled output halts the whole row.
`default_nettype none

module cumulative_mean_normalized_difference import cmnd_pkg::*; #(
  parameter int unsigned MAX_LAGS    = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire cmnd_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output cmnd_out_t      out_data_o
);

  localparam int unsigned LW = (MAX_LAGS > 2) ? $clog2(MAX_LAGS) : 1;
  localparam int unsigned TW = VALUE_WIDTH + 10;
  localparam int unsigned NW = VALUE_WIDTH + LW;
  localparam int unsigned CW = (NW > TW + IntBits) ? NW : TW + IntBits;

  logic                   adv_w;
  logic                   take_w;
  logic [VALUE_WIDTH-1:0] value_w;
  logic [LW-1:0]          lag_w;
  logic [TW-1:0]          den_w;

  logic                   a_valid_q;
  logic [VALUE_WIDTH-1:0] a_value_q;
  logic [LW-1:0]          a_lag_q;
  logic [TW-1:0]          a_den_q;
  cmnd_meta_t             a_meta_q;

  logic                   b_valid_q;
  logic [NW-1:0]          b_num_q;
  logic [TW-1:0]          b_den_q;
  cmnd_meta_t             b_meta_q;

  logic                   ovf_w;
  cmnd_meta_t             b_meta_w;

  logic                   c_valid   [0:QuotBits];
  logic [TW-1:0]          c_den     [0:QuotBits];
  logic [TW-1:0]          c_rem     [0:QuotBits];
  logic [IntBits-1:0]     c_num_lo  [0:QuotBits];
  logic [QuotBits-1:0]    c_quot    [0:QuotBits];
  cmnd_meta_t             c_meta    [0:QuotBits];

  logic                   out_valid_q;
  cmnd_out_t              out_data_q;
  cmnd_meta_t             fin_meta_w;

  assign adv_w      = !out_valid_q || out_ready_i;
  assign in_ready_o = adv_w;
  assign take_w     = in_valid_i && adv_w;
  assign value_w    = VALUE_WIDTH'(in_data_i.diff_value);

  cmnd_accum #(
    .MAX_LAGS   (MAX_LAGS),
    .VALUE_WIDTH(VALUE_WIDTH),
    .LW         (LW),
    .TW         (TW)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take_w),
    .value_i(value_w),
    .last_i (in_data_i.window_end),
    .lag_o  (lag_w),
    .den_o  (den_w)
  );

  // Valid bits of the front stages and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid[0]  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_w) begin
      a_valid_q   <= in_valid_i;
      b_valid_q   <= a_valid_q;
      c_valid[0]  <= b_valid_q;
      out_valid_q <= c_valid[QuotBits];
    end
  end

  // Capture the item, multiply, then prepare the divider
  always_comb begin
    ovf_w        = CW'(b_num_q) >= (CW'(b_den_q) << IntBits);
    b_meta_w     = b_meta_q;
    b_meta_w.ovf = ovf_w;
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      a_value_q          <= value_w;
      a_lag_q            <= lag_w;
      a_den_q            <= den_w;
      a_meta_q.last      <= in_data_i.window_end;
      a_meta_q.lag0      <= lag_w == '0;
      a_meta_q.zero_sum  <= (lag_w != '0) && (den_w == '0);
      a_meta_q.ovf       <= 1'b0;
      a_meta_q.lag_index <= LagWidth'(lag_w);

      b_num_q  <= NW'(a_value_q) * NW'(a_lag_q);
      b_den_q  <= a_den_q;
      b_meta_q <= a_meta_q;

      c_den[0]    <= b_den_q;
      c_rem[0]    <= TW'(b_num_q >> IntBits);
      c_num_lo[0] <= b_num_q[IntBits-1:0];
      c_quot[0]   <= '0;
      c_meta[0]   <= b_meta_w;
    end
  end

  for (genvar i = 0; i < QuotBits; i++) begin : g_cell
    cmnd_div_cell #(
      .TW  (TW),
      .STEP(i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv_w),
      .valid_i (c_valid[i]),
      .den_i   (c_den[i]),
      .rem_i   (c_rem[i]),
      .num_lo_i(c_num_lo[i]),
      .quot_i  (c_quot[i]),
      .meta_i  (c_meta[i]),
      .valid_o (c_valid[i+1]),
      .den_o   (c_den[i+1]),
      .rem_o   (c_rem[i+1]),
      .num_lo_o(c_num_lo[i+1]),
      .quot_o  (c_quot[i+1]),
      .meta_o  (c_meta[i+1])
    );
  end

  assign fin_meta_w = c_meta[QuotBits];

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      if (fin_meta_w.lag0) begin
        out_data_q.norm_value <= OneQ824;
      end else if (fin_meta_w.zero_sum || fin_meta_w.ovf) begin
        out_data_q.norm_value <= MaxCode;
      end else begin
        out_data_q.norm_value <= c_quot[QuotBits];
      end
      out_data_q.zero_sum    <= fin_meta_w.zero_sum;
      out_data_q.lag_index   <= fin_meta_w.lag_index;
      out_data_q.result_last <= fin_meta_w.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_sum |-> out_data_o.norm_value == MaxCode)
    else $error("zero sum result not saturated");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_w |=> c_valid[QuotBits] == $past(c_valid[QuotBits]))
    else $error("divider row moved during output stall");

  a_lag0_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[QuotBits] && fin_meta_w.lag0 |-> !fin_meta_w.zero_sum)
    else $error("lag zero flagged as zero sum");

endmodule

`default_nettype wire

// ===== dv/cumulative_mean_normalized_difference_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cumulative_mean_normalized_difference_tb
// Streams YIN difference windows through the block and checks every result
// against a cycle-free prediction of the running sum and the Q8.24 quotient,
// under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------

module cumulative_mean_normalized_difference_tb;
  import cmnd_pkg::*;

  localparam int unsigned MaxLags     = 1024;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned TotalItems  = 1900;
  localparam int unsigned TailLen     = 150;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 500;
  localparam int unsigned OverlongLen = 1100;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 80;

  localparam logic [41:0] TotalMax = '1;
  localparam logic [31:0] MaxVal   = '1;

  typedef enum logic [1:0] {
    MixDense,
    MixSparse,
    MixMax
  } value_mix_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  cmnd_in_t  in_data = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  cmnd_out_t out_data_o;

  cmnd_in_t  diff_items_q[$];
  cmnd_out_t norm_expect_q[$];

  logic [9:0]  lag_q = '0;
  logic [41:0] total_q = '0;

  logic        in_took = 1'b0;
  int unsigned n_items, n_windows, n_results, n_errors;
  int unsigned n_zero_sum, n_saturated, n_lag_zero;
  int unsigned stall_cycles;
  int unsigned tx_gap, rx_gap, hold_left;
  logic        hold_done = 1'b0;
  logic        tx_idle_en = 1'b1;
  logic        rx_idle_en = 1'b1;

  cumulative_mean_normalized_difference #(
    .MAX_LAGS    (MaxLags),
    .VALUE_WIDTH (ValueWidth)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic compute_norm_diff(input cmnd_in_t item, output cmnd_out_t res);
    logic [31:0] value;
    logic [42:0] sum_wide;
    logic [41:0] product;
    logic [65:0] quot;
    value = item.diff_value;
    res.zero_sum    = 1'b0;
    res.lag_index   = lag_q;
    res.result_last = item.window_end;
    if (lag_q == '0) begin
      res.norm_value = OneQ824;
    end else begin
      sum_wide = {1'b0, total_q} + 43'(value);
      total_q  = sum_wide[42] ? TotalMax : sum_wide[41:0];
      if (total_q == '0) begin
        res.norm_value = MaxCode;
        res.zero_sum   = 1'b1;
      end else begin
        product = 42'(value) * 42'(lag_q);
        if ((product / total_q) >= 42'd256) begin
          res.norm_value = MaxCode;
        end else begin
          quot = {product, 24'b0} / 66'(total_q);
          res.norm_value = quot[31:0];
        end
      end
    end
    if (item.window_end) begin
      lag_q   = '0;
      total_q = '0;
    end else if (lag_q < 10'(MaxLags - 1)) begin
      lag_q = lag_q + 10'd1;
    end
  endtask

  function automatic logic [31:0] pick_value(value_mix_e mix);
    logic [31:0] v;
    v = $urandom();
    case (mix)
      MixDense: begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = MaxVal;
          2, 3: v = $urandom_range(0, 255);
          default: ;
        endcase
      end
      MixSparse: begin
        if ($urandom_range(0, 15) != 0) v = '0;
        else if ($urandom_range(0, 1) != 0) v = $urandom_range(0, 255);
      end
      default: begin
        if ($urandom_range(0, 49) != 0) v = MaxVal;
      end
    endcase
    return v;
  endfunction

  task automatic push_item(input logic [31:0] value, input logic last);
    cmnd_in_t item;
    item.diff_value = value;
    item.window_end = last;
    diff_items_q.push_back(item);
    if (last) n_windows++;
  endtask

  task automatic push_window(input int unsigned len, input value_mix_e mix);
    for (int unsigned i = 0; i < len; i++) begin
      push_item(pick_value(mix), i == len - 1);
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      if (!in_valid || in_took) begin
        nxt_valid = 1'b0;
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (tx_idle_en && diff_items_q.size() > TailLen &&
                     $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 18);
        end else if (diff_items_q.size() != 0) begin
          in_data <= diff_items_q.pop_front();
          nxt_valid = 1'b1;
        end
        in_valid <= nxt_valid;
      end
      if ($urandom_range(0, 99) == 0) tx_idle_en = !tx_idle_en;
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_results >= HoldAfter) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (rx_idle_en && n_results + TailLen < n_items + diff_items_q.size() &&
                   $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) rx_idle_en = !rx_idle_en;
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    cmnd_out_t exp_res;
    logic      moved;
    if (rst_ni) begin
      moved = 1'b0;
      in_took <= in_valid && in_ready_o;
      if (in_valid && in_ready_o) begin
        compute_norm_diff(in_data, exp_res);
        norm_expect_q.push_back(exp_res);
        n_items++;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready) begin
        moved = 1'b1;
        n_results++;
        if (norm_expect_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          n_errors++;
        end else begin
          exp_res = norm_expect_q.pop_front();
          if (out_data_o.norm_value !== exp_res.norm_value) begin
            $display("%0t: norm_value expected %h actual %h", $time,
                     exp_res.norm_value, out_data_o.norm_value);
            n_errors++;
          end
          if (out_data_o.zero_sum !== exp_res.zero_sum) begin
            $display("%0t: zero_sum expected %b actual %b", $time,
                     exp_res.zero_sum, out_data_o.zero_sum);
            n_errors++;
          end
          if (out_data_o.lag_index !== exp_res.lag_index) begin
            $display("%0t: lag_index expected %0d actual %0d", $time,
                     exp_res.lag_index, out_data_o.lag_index);
            n_errors++;
          end
          if (out_data_o.result_last !== exp_res.result_last) begin
            $display("%0t: result_last expected %b actual %b", $time,
                     exp_res.result_last, out_data_o.result_last);
            n_errors++;
          end
          if (exp_res.zero_sum) n_zero_sum++;
          else if (exp_res.norm_value == MaxCode) n_saturated++;
          if (exp_res.lag_index == '0) n_lag_zero++;
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else if (++stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    bit overlong_done;
    int unsigned pick;
    overlong_done = 1'b0;

    // lone lag-zero windows
    push_item(MaxVal, 1'b1);
    push_item('0, 1'b1);
    // zero sums, then extremes
    push_item(32'h1234_5678, 1'b0);
    push_item('0, 1'b0);
    push_item('0, 1'b0);
    push_item(MaxVal, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item('0, 1'b1);
    push_item('0, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(MaxVal, 1'b0);
    push_item(MaxVal, 1'b0);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h5555_5555, 1'b0);
    push_item(32'hAAAA_AAAA, 1'b1);
    // quotient overflow: tiny sum at a large lag
    push_item(32'h0000_0005, 1'b0);
    for (int i = 1; i < 300; i++) push_item('0, 1'b0);
    push_item(32'h0001_0000, 1'b0);
    push_item(MaxVal, 1'b0);
    push_item(32'h0000_0003, 1'b1);

    while (diff_items_q.size() < TotalItems) begin
      if (!overlong_done && diff_items_q.size() > 400) begin
        // runs past the lag limit and saturates the running sum
        push_window(OverlongLen, MixMax);
        overlong_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) push_window($urandom_range(257, 330), MixSparse);
        else if (pick < 3) push_window($urandom_range(41, 256), MixSparse);
        else push_window($urandom_range(1, 40), MixDense);
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (diff_items_q.size() != 0 || in_valid || norm_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results from %0d items in %0d windows.", n_results, n_items,
             n_windows);
    $display("Lag-zero %0d, zero-sum %0d, saturated quotients %0d, mismatches %0d.",
             n_lag_zero, n_zero_sum, n_saturated, n_errors);
    if (n_errors == 0 && norm_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
